### design/ffc_pkg.sv
// ============================================================================
// ffc_pkg
// Shared types, codes and helpers for the float/fixed format converter.
// ============================================================================
package ffc_pkg;

    localparam int WORD_W  = 64;    // widest source/target word
    localparam int CFG_W   = 7;     // widest configuration register
    localparam int ADDR_W  = 3;     // configuration index width
    localparam int EXP_W   = 18;    // decoded binary exponent, signed
    localparam int CALC_W  = 20;    // exponent arithmetic in the encoder, signed
    localparam int EF_W    = 15;    // widest float exponent field
    localparam int POS_W   = 6;     // bit position inside a word
    localparam int SH_W    = 7;     // shift amount, saturates at 127
    localparam int TDATA_W = 72;    // output payload padded to whole bytes

    localparam int MIN_MANT  = 1;
    localparam int MIN_EXP   = 2;
    localparam int MAX_EXP   = 15;
    localparam int MIN_FIXED = 2;

    // format codes
    localparam logic [1:0] FMT_FLOAT = 2'd0;
    localparam logic [1:0] FMT_UFIX  = 2'd1;
    localparam logic [1:0] FMT_SFIX  = 2'd2;

    // value class
    localparam logic [1:0] CLS_NORM = 2'd0;
    localparam logic [1:0] CLS_INF  = 2'd1;
    localparam logic [1:0] CLS_NAN  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_NEG = 2'd1;
    localparam logic [1:0] ST_NAN = 2'd2;
    localparam logic [1:0] ST_BAD = 2'd3;

    // configuration register indexes
    localparam logic [ADDR_W-1:0] REG_IN_FORMAT   = 3'd0;
    localparam logic [ADDR_W-1:0] REG_IN_FRAC     = 3'd1;
    localparam logic [ADDR_W-1:0] REG_IN_EXP_W    = 3'd2;
    localparam logic [ADDR_W-1:0] REG_OUT_FORMAT  = 3'd3;
    localparam logic [ADDR_W-1:0] REG_OUT_FRAC    = 3'd4;
    localparam logic [ADDR_W-1:0] REG_OUT_EXP_W   = 3'd5;

    typedef struct packed {
        logic [WORD_W-1:0]      mag;
        logic signed [EXP_W-1:0] exp;
        logic                   neg;
        logic [1:0]             cls;
    } decoded_t;

    function automatic logic [WORD_W-1:0] low_mask(input logic [CFG_W-1:0] w);
        logic [WORD_W-1:0] r;
        if (w >= CFG_W'(WORD_W))
            r = '1;
        else
            r = (WORD_W'(1) << w) - WORD_W'(1);
        return r;
    endfunction

    function automatic logic [EF_W-1:0] exp_mask(input logic [CFG_W-1:0] e);
        return (EF_W'(1) << e[3:0]) - EF_W'(1);
    endfunction

    function automatic logic [POS_W-1:0] top_bit(input logic [WORD_W-1:0] v);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (v[i])
                p = POS_W'(i);
        end
        return p;
    endfunction

    function automatic logic fmt_ok(input logic [1:0] fmt, input logic [CFG_W-1:0] frac,
                                    input logic [CFG_W-1:0] ew);
        logic ok;
        case (fmt)
            FMT_FLOAT:
                ok = (frac >= CFG_W'(MIN_MANT)) && (ew >= CFG_W'(MIN_EXP)) &&
                     (ew <= CFG_W'(MAX_EXP)) &&
                     (({1'b0, frac} + {1'b0, ew}) <= 8'(WORD_W - 1));
            FMT_UFIX, FMT_SFIX:
                ok = (ew >= CFG_W'(MIN_FIXED)) && (ew <= CFG_W'(WORD_W)) && (frac <= ew);
            default:
                ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

### design/float_fixed_format_converter_core.sv
// ============================================================================
// float_fixed_format_converter_core
// Re-encodes words between configurable float and fixed-point formats.
// ============================================================================
// One word enters per clock unless back-pressure stalls the input; it
// passes through six register stages (decode, leading-one search,
// exponent and shift arithmetic, barrel shift, rounding, packing). Each stage
// holds only while the stage after it is full and stalled, so bubbles close
// up under back-pressure. Configuration is read live by the decode, exponent,
// rounding and packing stages: write it only while nothing is in flight.
module float_fixed_format_converter_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ffc_pkg::ADDR_W-1:0]    cfg_addr,
    input  logic [ffc_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [ffc_pkg::WORD_W-1:0]    s_axis_tdata,   // [63:0] source_word
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [ffc_pkg::TDATA_W-1:0]   m_axis_tdata    // [63:0] target_word,
                                                          // [65:64] status
);
    import ffc_pkg::*;

    // configuration
    logic [1:0]       in_format_reg, out_format_reg;
    logic [CFG_W-1:0] in_frac_reg, in_ew_reg, out_frac_reg, out_ew_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_format_reg  <= FMT_FLOAT;
            in_frac_reg    <= CFG_W'(23);
            in_ew_reg      <= CFG_W'(8);
            out_format_reg <= FMT_SFIX;
            out_frac_reg   <= CFG_W'(16);
            out_ew_reg     <= CFG_W'(32);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_IN_FORMAT:  in_format_reg  <= cfg_data[1:0];
                REG_IN_FRAC:    in_frac_reg    <= cfg_data;
                REG_IN_EXP_W:   in_ew_reg      <= cfg_data;
                REG_OUT_FORMAT: out_format_reg <= cfg_data[1:0];
                REG_OUT_FRAC:   out_frac_reg   <= cfg_data;
                REG_OUT_EXP_W:  out_ew_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    logic cfg_ok;
    logic out_float, out_sfix;
    assign cfg_ok    = fmt_ok(in_format_reg, in_frac_reg, in_ew_reg) &&
                       fmt_ok(out_format_reg, out_frac_reg, out_ew_reg);
    assign out_float = (out_format_reg == FMT_FLOAT);
    assign out_sfix  = (out_format_reg == FMT_SFIX);

    // stage valids and load enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic ld1, ld2, ld3, ld4, ld5, ld6;

    assign ld6 = !v6_reg || m_axis_tready;
    assign ld5 = !v5_reg || ld6;
    assign ld4 = !v4_reg || ld5;
    assign ld3 = !v3_reg || ld4;
    assign ld2 = !v2_reg || ld3;
    assign ld1 = !v1_reg || ld2;
    assign s_axis_tready = ld1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (ld1) v1_reg <= s_axis_tvalid;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
            if (ld4) v4_reg <= v3_reg;
            if (ld5) v5_reg <= v4_reg;
            if (ld6) v6_reg <= v5_reg;
        end
    end

    // stage 1: decode
    decoded_t dec_next, s1_reg;

    ffc_decode u_decode (
        .word (s_axis_tdata),
        .fmt  (in_format_reg),
        .frac (in_frac_reg),
        .ew   (in_ew_reg),
        .dec  (dec_next)
    );

    always_ff @(posedge clk)
    begin
        if (ld1)
            s1_reg <= dec_next;
    end

    // stage 2: leading one
    decoded_t         s2_reg;
    logic [POS_W-1:0] s2_p_reg;
    logic             s2_nz_reg;

    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            s2_reg    <= s1_reg;
            s2_p_reg  <= top_bit(s1_reg.mag);
            s2_nz_reg <= (s1_reg.mag != '0);
        end
    end

    // stage 3: exponent and shift amount; positive shift means right
    logic [EF_W-1:0]          emask_o;
    logic signed [CALC_W-1:0] exp20, p20, m20, bias20, emask20, fpos20;
    logic signed [CALC_W-1:0] ex, t_f, d, t_x, t, t_abs;
    logic                     f_inf, f_sub, ovf_x;
    logic [CFG_W-1:0]         fpos;

    always_comb
    begin
        emask_o = exp_mask(out_ew_reg);
        exp20   = CALC_W'(s2_reg.exp);
        p20     = CALC_W'(s2_p_reg);
        m20     = CALC_W'(out_frac_reg);
        bias20  = CALC_W'(emask_o >> 1);
        emask20 = CALC_W'(emask_o);
        fpos    = out_sfix ? (out_ew_reg - CFG_W'(2)) : (out_ew_reg - CFG_W'(1));
        fpos20  = CALC_W'(fpos);

        ex    = exp20 + bias20 + p20;
        f_inf = (ex >= emask20);
        f_sub = (ex <= 0);
        // below the normal range: one extra place for the hidden bit
        t_f   = f_sub ? (p20 - m20 + CALC_W'(1) - ex) : (p20 - m20);

        d     = exp20 + m20;
        t_x   = -d;
        ovf_x = s2_nz_reg && ((p20 + d) > fpos20);

        t     = out_float ? t_f : t_x;
        t_abs = (t > 0) ? t : -t;
    end

    decoded_t         s3_reg;
    logic             s3_nz_reg, s3_ovf_reg, s3_right_reg;
    logic [SH_W-1:0]  s3_amt_reg;
    logic [EF_W-1:0]  s3_exf_reg;

    always_ff @(posedge clk)
    begin
        if (ld3)
        begin
            s3_reg       <= s2_reg;
            s3_nz_reg    <= s2_nz_reg;
            s3_ovf_reg   <= out_float ? f_inf : ovf_x;
            s3_right_reg <= (t > 0);
            s3_amt_reg   <= (t_abs > CALC_W'({SH_W{1'b1}})) ? {SH_W{1'b1}} : t_abs[SH_W-1:0];
            s3_exf_reg   <= f_sub ? '0 : ex[EF_W-1:0];
        end
    end

    // stage 4: barrel shift and round bit
    logic [WORD_W-1:0] rr_word;
    assign rr_word = s3_reg.mag >> (s3_amt_reg - SH_W'(1));

    decoded_t          s4_reg;
    logic [WORD_W-1:0] s4_sh_reg;
    logic              s4_rr_reg, s4_nz_reg, s4_ovf_reg, s4_right_reg;
    logic [EF_W-1:0]   s4_exf_reg;

    always_ff @(posedge clk)
    begin
        if (ld4)
        begin
            s4_reg       <= s3_reg;
            s4_sh_reg    <= s3_right_reg ? (s3_reg.mag >> s3_amt_reg)
                                         : (s3_reg.mag << s3_amt_reg);
            s4_rr_reg    <= s3_right_reg && rr_word[0];
            s4_nz_reg    <= s3_nz_reg;
            s4_ovf_reg   <= s3_ovf_reg;
            s4_right_reg <= s3_right_reg;
            s4_exf_reg   <= s3_exf_reg;
        end
    end

    // stage 5: rounding, specials and status
    logic [WORD_W-1:0] mmask_f, fb, mm, dm, n0, val;
    logic [EF_W-1:0]   exf;
    logic [1:0]        status;
    logic              do_neg;

    always_comb
    begin
        mmask_f = low_mask(out_frac_reg);
        fb      = WORD_W'(1) << fpos;
        mm      = out_sfix ? low_mask(out_ew_reg - CFG_W'(1)) : low_mask(out_ew_reg);
        dm      = low_mask(out_ew_reg);
        n0      = (s4_sh_reg | (s4_ovf_reg ? fb : '0)) & mm;
        val     = '0;
        exf     = '0;
        status  = ST_OK;
        do_neg  = 1'b0;
        if (out_float)
        begin
            case (s4_reg.cls)
                CLS_NAN:
                begin
                    val = WORD_W'(1);
                    exf = emask_o;
                end
                CLS_INF:
                    exf = emask_o;
                default:
                begin
                    if (!s4_nz_reg)
                        exf = '0;
                    else if (s4_ovf_reg)
                        exf = emask_o;
                    else
                    begin
                        // carry out of the field is dropped
                        val = ((s4_sh_reg & mmask_f) + WORD_W'(s4_rr_reg)) & mmask_f;
                        exf = s4_exf_reg;
                    end
                end
            endcase
        end
        else
        begin
            if (s4_reg.cls == CLS_NAN)
                status = ST_NAN;
            else if (s4_reg.neg && !out_sfix)
                status = ST_NEG;
            else if (s4_reg.cls == CLS_INF)
                val = s4_reg.neg ? (fb << 1) : mm;
            else
            begin
                val    = (n0 != dm) ? (n0 + WORD_W'(s4_rr_reg)) : n0;
                do_neg = s4_reg.neg;
            end
        end
        if (!cfg_ok)
            status = ST_BAD;
    end

    logic [WORD_W-1:0] s5_val_reg;
    logic [EF_W-1:0]   s5_exf_reg;
    logic [1:0]        s5_status_reg;
    logic              s5_neg_reg, s5_do_neg_reg;

    always_ff @(posedge clk)
    begin
        if (ld5)
        begin
            s5_val_reg    <= val;
            s5_exf_reg    <= exf;
            s5_status_reg <= status;
            s5_neg_reg    <= s4_reg.neg;
            s5_do_neg_reg <= do_neg;
        end
    end

    // stage 6: pack or negate
    logic [WORD_W-1:0] word;

    always_comb
    begin
        if (s5_status_reg != ST_OK)
            word = '0;
        else if (out_float)
            word = s5_val_reg | (WORD_W'(s5_exf_reg) << out_frac_reg) |
                   (WORD_W'(s5_neg_reg) << ({1'b0, out_frac_reg} + {1'b0, out_ew_reg}));
        else if (s5_do_neg_reg)
            word = (~s5_val_reg + WORD_W'(1)) & dm;
        else
            word = s5_val_reg;
    end

    logic [WORD_W-1:0] s6_word_reg;
    logic [1:0]        s6_status_reg;

    always_ff @(posedge clk)
    begin
        if (ld6)
        begin
            s6_word_reg   <= word;
            s6_status_reg <= s5_status_reg;
        end
    end

    assign m_axis_tvalid = v6_reg;
    assign m_axis_tdata  = {{(TDATA_W - WORD_W - 2){1'b0}}, s6_status_reg, s6_word_reg};

    // a failed conversion never carries a payload
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (v6_reg && s6_status_reg != ST_OK) |-> (s6_word_reg == '0))
        else $error("nonzero status with nonzero word");

    // round bit only comes from a right shift
    a_rr_right: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && s4_rr_reg) |-> s4_right_reg)
        else $error("round bit set on left shift");

    // a stalled stage keeps its item
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !ld3) |=> v2_reg)
        else $error("stage 2 item dropped under stall");

endmodule

### design/ffc_decode.sv
// ============================================================================
// ffc_decode
// Splits a raw source word into sign, magnitude, binary exponent and class.
// ============================================================================
module ffc_decode (
    input  logic [ffc_pkg::WORD_W-1:0] word,
    input  logic [1:0]                 fmt,
    input  logic [ffc_pkg::CFG_W-1:0]  frac,
    input  logic [ffc_pkg::CFG_W-1:0]  ew,
    output ffc_pkg::decoded_t          dec
);
    import ffc_pkg::*;

    logic [EF_W-1:0]   emask;
    logic [EF_W-1:0]   bias;
    logic [WORD_W-1:0] ef_word;
    logic [EF_W-1:0]   ef;
    logic [EF_W-1:0]   ef_adj;
    logic [WORD_W-1:0] man;
    logic [WORD_W-1:0] sgn_word;
    logic [WORD_W-1:0] fx_word;
    logic [WORD_W-1:0] fx_top;
    logic [WORD_W-1:0] dm;
    logic              fx_neg;

    always_comb
    begin
        emask    = exp_mask(ew);
        bias     = emask >> 1;
        ef_word  = word >> frac;
        ef       = ef_word[EF_W-1:0] & emask;
        sgn_word = word >> ({1'b0, frac} + {1'b0, ew});
        man      = word & low_mask(frac);
        dm       = low_mask(ew);
        fx_word  = word & dm;
        fx_top   = fx_word >> (ew - CFG_W'(1));
        fx_neg   = (fmt == FMT_SFIX) && fx_top[0];

        if (fmt == FMT_FLOAT)
        begin
            dec.neg = sgn_word[0];
            dec.cls = CLS_NORM;
            dec.mag = man;
            ef_adj  = ef;
            if (ef == emask)
            begin
                dec.cls = (man == '0) ? CLS_INF : CLS_NAN;
                dec.exp = '0;
            end
            else
            begin
                // subnormals share the exponent of the smallest normal
                if (ef == '0)
                    ef_adj = EF_W'(1);
                else
                    dec.mag = man | (WORD_W'(1) << frac);
                dec.exp = EXP_W'(ef_adj) - EXP_W'(frac) - EXP_W'(bias);
            end
        end
        else
        begin
            ef_adj  = ef;
            dec.cls = CLS_NORM;
            dec.neg = fx_neg;
            dec.exp = -EXP_W'(frac);
            dec.mag = fx_neg ? ((~fx_word + WORD_W'(1)) & dm) : fx_word;
        end
    end

endmodule
